// ===== rtl/core/rtnbr_pkg.sv =====
// Shared types and constants of the raster to nozzle band runs block.
package rtnbr_pkg;

    localparam int LANES  = 8;
    localparam int SLOTS  = LANES + 1;
    localparam int COL_W  = 12;
    localparam int PAT_W  = 16;
    localparam int BAND_W = 16;
    localparam int PIX_W  = 8;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NOZZLE_COUNT = 2'd2;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
    localparam logic [4:0]  RST_NOZZLE_COUNT = 5'd12;

    // Per-byte control handed from the accept stage to the run encoder.
    typedef struct packed {
        logic              closing;
        logic              row_end;
        logic [LANES-1:0]  lane_ok;
        logic [LANES-1:0]  lane_end;
        logic [COL_W-1:0]  col;
        logic [BAND_W-1:0] band;
    } t_ctl;

    typedef struct packed {
        logic [COL_W-1:0] run_start;
        logic [COL_W-1:0] run_end;
        logic [PAT_W-1:0] pattern;
    } t_run;

    // All results caused by one byte: a break slot per lane, then the row end.
    typedef struct packed {
        logic [BAND_W-1:0]        band;
        logic                     first;
        logic [SLOTS-1:0]         valid;
        t_run [SLOTS-1:0]         slot;
    } t_batch;

endpackage

// ===== rtl/core/rtnbr_if.sv =====
// Valid/ready channel interfaces for raster bytes and run results.
interface rtnbr_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rtnbr_pkg::PIX_W-1:0]   pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

interface rtnbr_run_if;
    logic                          valid;
    logic                          ready;
    logic [rtnbr_pkg::BAND_W-1:0]  band_index;
    logic [rtnbr_pkg::COL_W-1:0]   run_start;
    logic [rtnbr_pkg::COL_W-1:0]   run_end;
    logic [rtnbr_pkg::PAT_W-1:0]   pattern;
    logic                          first_of_band;
    logic                          last;

    modport source (output valid, output band_index, output run_start, output run_end,
                    output pattern, output first_of_band, output last, input ready);
    modport sink (input valid, input band_index, input run_start, input run_end,
                  input pattern, input first_of_band, input last, output ready);
endinterface

// ===== rtl/core/raster_to_nozzle_band_runs_unit.sv =====
// Top level of the raster to nozzle band runs block.
//
// Raster bytes enter on i_pix (valid/ready), eight pixels each, leftmost pixel in
// bit 7, rows padded to whole bytes. Rows are gathered into bands of nozzle_count
// rows in a column mask memory of MAX_WIDTH/8 rows of eight masks. On the closing
// row of a band, or the last row of the image, the masks are cleared and encoded
// into runs that leave on o_run, one per transfer, with last set on the final run
// caused by a byte.
//
// One byte is accepted per cycle unless results back up: eight column lanes update
// eight masks at once and the memory is read on accept and written back when the
// encoder stage advances. A byte that yields k runs occupies the single result port
// for k transfers, so input slows while such bytes follow each other. After reset
// the mask memory is cleared one row per cycle, all MAX_WIDTH/8 rows (512 at the
// default size), with i_pix.ready low. When the receiver stalls, the output register,
// one byte's result buffer and the encoder stage fill up, after which i_pix.ready
// drops; bytes that produce no runs still pass meanwhile. The user must write the
// registers over the APB port only while the block is idle; it does not enforce this.
module raster_to_nozzle_band_runs_unit #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_NOZZLES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rtnbr_pix_if.sink                        i_pix,
    rtnbr_run_if.source                      o_run,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtnbr_pkg::CFG_AW-1:0]     paddr,
    input  logic [rtnbr_pkg::CFG_DW-1:0]     pwdata,
    output logic [rtnbr_pkg::CFG_DW-1:0]     prdata,
    output logic                             pready
);

    localparam int CW    = $clog2(MAX_WIDTH) + 1;
    localparam int CX    = CW + 1;
    localparam int ROWS  = MAX_WIDTH / 8;
    localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MW    = MAX_NOZZLES;
    localparam int LANES = rtnbr_pkg::LANES;

    // Configuration registers.
    logic [12:0] r_image_width;
    logic [15:0] r_image_height;
    logic [4:0]  r_nozzle_count;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rtnbr_pkg::RST_IMAGE_WIDTH;
            r_image_height <= rtnbr_pkg::RST_IMAGE_HEIGHT;
            r_nozzle_count <= rtnbr_pkg::RST_NOZZLE_COUNT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rtnbr_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[12:0];
                rtnbr_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[15:0];
                rtnbr_pkg::REG_NOZZLE_COUNT: r_nozzle_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rtnbr_pkg::REG_IMAGE_WIDTH:  prdata = rtnbr_pkg::CFG_DW'(r_image_width);
            rtnbr_pkg::REG_IMAGE_HEIGHT: prdata = rtnbr_pkg::CFG_DW'(r_image_height);
            rtnbr_pkg::REG_NOZZLE_COUNT: prdata = rtnbr_pkg::CFG_DW'(r_nozzle_count);
            default:                     prdata = '0;
        endcase
    end

    // Effective geometry with out-of-range values clamped.
    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [4:0]    n_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_image_width);
        end
        h_eff = (r_image_height == '0) ? 16'd1 : r_image_height;
        if (r_nozzle_count == '0) begin
            n_eff = 5'd1;
        end else if (32'(r_nozzle_count) > MAX_NOZZLES) begin
            n_eff = 5'(MAX_NOZZLES);
        end else begin
            n_eff = r_nozzle_count;
        end
    end

    // Position counters.
    logic [CW-1:0]                r_col;
    logic [15:0]                  r_row;
    logic [3:0]                   r_rib;
    logic [rtnbr_pkg::BAND_W-1:0] r_band;

    logic          accept;
    logic          last_row;
    logic          closing;
    logic          row_end;
    logic [CX-1:0] col_ext;
    logic [CX-1:0] w_ext;
    rtnbr_pkg::t_ctl ctl0;

    always_comb begin
        logic [CX-1:0] lane_c;
        col_ext  = {1'b0, r_col};
        w_ext    = {1'b0, w_eff};
        last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};
        closing  = last_row || (({1'b0, r_rib} + 5'd1) >= n_eff);
        row_end  = (col_ext + CX'(8)) >= w_ext;
        ctl0          = '0;
        ctl0.closing  = closing;
        ctl0.row_end  = row_end;
        ctl0.col      = rtnbr_pkg::COL_W'(32'(r_col));
        ctl0.band     = r_band;
        for (int k = 0; k < LANES; k++) begin
            lane_c           = col_ext + CX'(k);
            ctl0.lane_ok[k]  = lane_c < w_ext;
            ctl0.lane_end[k] = lane_c == (w_ext - CX'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rib  <= '0;
            r_band <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_rib  <= '0;
                    r_band <= '0;
                end else begin
                    r_row <= r_row + 16'd1;
                    if (closing) begin
                        r_rib  <= '0;
                        r_band <= r_band + 1'b1;
                    end else begin
                        r_rib <= r_rib + 4'd1;
                    end
                end
            end else begin
                r_col <= r_col + CW'(8);
            end
        end
    end

    // Clearing pass over the mask memory after reset.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Encoder stage registers.
    logic                     r_s1_valid;
    logic [7:0]               r_s1_byte;
    logic [3:0]               r_s1_bit;
    logic [AW-1:0]            r_s1_addr;
    rtnbr_pkg::t_ctl          r_s1_ctl;
    logic                     s1_adv;
    logic                     emit_free;
    rtnbr_pkg::t_batch        batch;

    assign s1_adv      = r_s1_valid && (!(|batch.valid) || emit_free);
    assign i_pix.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_pix.pixel_byte;
            r_s1_bit  <= r_rib;
            r_s1_addr <= AW'(r_col >> 3);
            r_s1_ctl  <= ctl0;
        end
    end

    // Mask memory, one row holds the masks of eight adjacent columns.
    logic [LANES-1:0][MW-1:0] mem [ROWS];
    logic [LANES-1:0][MW-1:0] r_rdata;
    logic [LANES-1:0][MW-1:0] r_fwd_data;
    logic                     r_fwd;
    logic [LANES-1:0][MW-1:0] row_data;
    logic [LANES-1:0][MW-1:0] s1_store;
    logic [LANES-1:0][MW-1:0] lane_mask;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [LANES-1:0][MW-1:0] wr_data;
    logic [AW-1:0]            rd_addr;

    assign rd_addr  = AW'(r_col >> 3);
    assign wr_en    = r_clr_busy || s1_adv;
    assign wr_addr  = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign wr_data  = r_clr_busy ? '0 : s1_store;
    // A row written back in the same cycle as it is read is taken from the write.
    assign row_data = r_fwd ? r_fwd_data : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rdata    <= mem[rd_addr];
            r_fwd      <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= wr_data;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        rtnbr_lane #(
            .MW (MW)
        ) u_lane (
            .i_old     (row_data[k]),
            .i_pix     (r_s1_byte[7-k]),
            .i_bit     (r_s1_bit),
            .i_closing (r_s1_ctl.closing),
            .i_ok      (r_s1_ctl.lane_ok[k]),
            .o_mask    (lane_mask[k]),
            .o_store   (s1_store[k])
        );
    end

    rtnbr_merge #(
        .MW (MW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_ctl   (r_s1_ctl),
        .i_mask  (lane_mask),
        .o_batch (batch)
    );

    rtnbr_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s1_adv && (|batch.valid)),
        .i_batch   (batch),
        .o_free    (emit_free),
        .o_valid   (o_run.valid),
        .i_ready   (o_run.ready),
        .o_band    (o_run.band_index),
        .o_start   (o_run.run_start),
        .o_end     (o_run.run_end),
        .o_pattern (o_run.pattern),
        .o_first   (o_run.first_of_band),
        .o_last    (o_run.last)
    );

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!i_pix.ready && !r_s1_valid))
        else $error("byte taken while the mask memory is being cleared");

    a_single_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $onehot0(r_s1_ctl.lane_end))
        else $error("more than one lane marked as the last column");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("encoder stage lost its byte while stalled");

endmodule

// ===== rtl/core/rtnbr_lane.sv =====
// One column lane: merges a pixel into its nozzle mask and forms the value stored back.
module rtnbr_lane #(
    parameter int MW = 16
) (
    input  logic [MW-1:0] i_old,
    input  logic          i_pix,
    input  logic [3:0]    i_bit,
    input  logic          i_closing,
    input  logic          i_ok,
    output logic [MW-1:0] o_mask,
    output logic [MW-1:0] o_store
);

    always_comb begin
        o_mask = i_old | (i_pix ? (MW'(1) << i_bit) : '0);
        if (!i_ok) begin
            o_store = i_old;
        end else if (i_closing) begin
            o_store = '0;
        end else begin
            o_store = o_mask;
        end
    end

endmodule

// ===== rtl/core/rtnbr_merge.sv =====
// Run encoder: walks the eight lane masks of a closing row and holds the open run.
module rtnbr_merge #(
    parameter int MW = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  rtnbr_pkg::t_ctl                        i_ctl,
    input  logic [rtnbr_pkg::LANES-1:0][MW-1:0]    i_mask,
    output rtnbr_pkg::t_batch                      o_batch
);

    logic                          r_run_open;
    logic [rtnbr_pkg::COL_W-1:0]   r_run_origin;
    logic [MW-1:0]                 r_run_mask;
    logic                          r_first_given;

    logic                          n_run_open;
    logic [rtnbr_pkg::COL_W-1:0]   n_run_origin;
    logic [MW-1:0]                 n_run_mask;

    always_comb begin
        logic                        open;
        logic [rtnbr_pkg::COL_W-1:0] origin;
        logic [MW-1:0]               mask;
        logic [rtnbr_pkg::COL_W-1:0] ck;
        open   = r_run_open;
        origin = r_run_origin;
        mask   = r_run_mask;
        o_batch       = '0;
        o_batch.band  = i_ctl.band;
        o_batch.first = !r_first_given;
        for (int k = 0; k < rtnbr_pkg::LANES; k++) begin
            ck = i_ctl.col + rtnbr_pkg::COL_W'(k);
            if (i_ctl.closing && i_ctl.lane_ok[k]) begin
                if (!open) begin
                    if (i_mask[k] != '0) begin
                        open   = 1'b1;
                        origin = ck;
                        mask   = i_mask[k];
                    end
                end else if (i_mask[k] != mask) begin
                    o_batch.valid[k]          = 1'b1;
                    o_batch.slot[k].run_start = origin;
                    o_batch.slot[k].run_end   = ck - 1'b1;
                    o_batch.slot[k].pattern   = rtnbr_pkg::PAT_W'(mask);
                    origin = ck;
                    mask   = i_mask[k];
                end
                if (i_ctl.lane_end[k] && open) begin
                    o_batch.valid[rtnbr_pkg::SLOTS-1]          = 1'b1;
                    o_batch.slot[rtnbr_pkg::SLOTS-1].run_start = origin;
                    o_batch.slot[rtnbr_pkg::SLOTS-1].run_end   = ck;
                    o_batch.slot[rtnbr_pkg::SLOTS-1].pattern   = rtnbr_pkg::PAT_W'(mask);
                    open = 1'b0;
                end
            end
        end
        n_run_open   = open;
        n_run_origin = origin;
        n_run_mask   = mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open    <= 1'b0;
            r_run_origin  <= '0;
            r_run_mask    <= '0;
            r_first_given <= 1'b0;
        end else if (i_adv) begin
            r_run_origin <= n_run_origin;
            if (i_ctl.row_end && i_ctl.closing) begin
                // A closing row that ends drops whatever run is still open.
                r_run_open    <= 1'b0;
                r_run_mask    <= '0;
                r_first_given <= 1'b0;
            end else begin
                r_run_open <= n_run_open;
                r_run_mask <= n_run_mask;
                if (|o_batch.valid) begin
                    r_first_given <= 1'b1;
                end
            end
        end
    end

    a_runs_only_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (|o_batch.valid)) |-> i_ctl.closing)
        else $error("run result produced on a row that does not close a band");

endmodule

// ===== rtl/core/rtnbr_emit.sv =====
// Result buffer: holds one byte's batch of runs and sends them out one transfer at a time.
module rtnbr_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  rtnbr_pkg::t_batch                 i_batch,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rtnbr_pkg::BAND_W-1:0]      o_band,
    output logic [rtnbr_pkg::COL_W-1:0]       o_start,
    output logic [rtnbr_pkg::COL_W-1:0]       o_end,
    output logic [rtnbr_pkg::PAT_W-1:0]       o_pattern,
    output logic                              o_first,
    output logic                              o_last
);

    logic [rtnbr_pkg::SLOTS-1:0]   r_pend;
    logic                          r_first;
    logic [rtnbr_pkg::BAND_W-1:0]  r_band;
    rtnbr_pkg::t_run [rtnbr_pkg::SLOTS-1:0] r_slot;

    logic                          r_out_valid;
    logic [rtnbr_pkg::BAND_W-1:0]  r_out_band;
    rtnbr_pkg::t_run               r_out_run;
    logic                          r_out_first;
    logic                          r_out_last;

    logic [rtnbr_pkg::SLOTS-1:0]   pick;
    logic [rtnbr_pkg::SLOTS-1:0]   rest;
    logic [rtnbr_pkg::SLOTS-1:0]   n_pend;
    logic                          take;
    rtnbr_pkg::t_run               sel_run;

    always_comb begin
        pick = r_pend & (~r_pend + 1'b1);
        rest = r_pend & ~pick;
        take = (|r_pend) && (!r_out_valid || i_ready);
        n_pend = take ? rest : r_pend;
        o_free = (n_pend == '0);
        sel_run = '0;
        for (int s = 0; s < rtnbr_pkg::SLOTS; s++) begin
            if (pick[s]) begin
                sel_run = sel_run | r_slot[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (take) begin
                r_first     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_pend  <= i_batch.valid;
                r_first <= i_batch.first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_band <= i_batch.band;
            r_slot <= i_batch.slot;
        end
        if (take) begin
            r_out_band  <= r_band;
            r_out_run   <= sel_run;
            r_out_first <= r_first;
            r_out_last  <= (rest == '0);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_band    = r_out_band;
    assign o_start   = r_out_run.run_start;
    assign o_end     = r_out_run.run_end;
    assign o_pattern = r_out_run.pattern;
    assign o_first   = r_out_first;
    assign o_last    = r_out_last;

    // The results of one byte leave without a gap in valid.
    a_batch_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |=> r_out_valid)
        else $error("result sequence of a byte broken before its last result");

endmodule
